### sv/llfd_pkg.sv
package llfd_pkg;

  // Default table geometry.
  localparam int NUM_SLOTS_DEF      = 10;
  localparam int FILES_PER_SLOT_DEF = 10;

  // Load limit after reset, and the saturating top of a client's load.
  localparam logic [6:0] LOAD_LIMIT_RESET = 7'd100;
  localparam logic [6:0] LOAD_MAX         = 7'd127;

  // Request actions.
  localparam logic [1:0] ACT_REGISTER   = 2'd0;
  localparam logic [1:0] ACT_LOOKUP     = 2'd1;
  localparam logic [1:0] ACT_DISCONNECT = 2'd2;

  // Response status codes.
  typedef enum logic [2:0] {
    ST_REGISTERED   = 3'd0,
    ST_FOUND        = 3'd1,
    ST_NOT_FOUND    = 3'd2,
    ST_DISCONNECTED = 3'd3,
    ST_UNKNOWN      = 3'd4,
    ST_TABLE_FULL   = 3'd5,
    ST_LIST_FULL    = 3'd6
  } status_t;

  // Request beat.
  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] client_port;
    logic [63:0] file_key;
  } req_t;

  // Response beat.
  typedef struct packed {
    status_t     status;
    logic [15:0] server_port;
  } resp_t;

endpackage

### sv/llfd_key_store.sv
module llfd_key_store import llfd_pkg::*; #(
  parameter int DEPTH = NUM_SLOTS_DEF * FILES_PER_SLOT_DEF
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [63:0]                               wr_key,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  input  logic [63:0]                               cmp_key,
  output logic                                      hit
);

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_data;

  // Single write port for appends.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_key;
    end
  end

  // Registered read port used by the lookup scan.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  // The stored key read last cycle matches the key being looked up.
  assign hit = (rd_data == cmp_key);

endmodule

### sv/least_loaded_file_directory.sv
// Directory of up to NUM_SLOTS serving clients, each holding a port, a load count and up
// to FILES_PER_SLOT 64-bit file keys kept in a key memory with one write port and one
// registered read port. One request is worked at a time. Register and disconnect walk the
// slot table one slot per cycle, and a lookup reads the key memory one entry per cycle
// over every slot and file position; the result is then resolved and waits for the output
// register to be free. A new request is accepted while the previous response still waits
// in the output register. The load limit may only be written while no request is in
// flight.
module least_loaded_file_directory import llfd_pkg::*; #(
  parameter int NUM_SLOTS      = NUM_SLOTS_DEF,
  parameter int FILES_PER_SLOT = FILES_PER_SLOT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req,
  output logic       resp_valid,
  input  logic       resp_stall,
  output resp_t      resp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  localparam int DEPTH = NUM_SLOTS * FILES_PER_SLOT;
  localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int FW    = (FILES_PER_SLOT > 1) ? $clog2(FILES_PER_SLOT) : 1;
  localparam int CW    = $clog2(FILES_PER_SLOT + 1);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);
  localparam logic [FW-1:0] LAST_FILE = FW'(FILES_PER_SLOT - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(FILES_PER_SLOT);
  localparam logic [AW-1:0] ROW_SIZE  = AW'(FILES_PER_SLOT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SLOT_SCAN,
    S_KEY_SCAN,
    S_KEY_DRAIN,
    S_FINISH
  } state_t;

  state_t state;

  // Configuration and the request being worked.
  logic [6:0]  load_limit;
  logic [1:0]  cur_action;
  logic [15:0] cur_port;
  logic [63:0] cur_key;

  // Slot table.
  logic          slot_used  [NUM_SLOTS];
  logic [15:0]   slot_port  [NUM_SLOTS];
  logic [6:0]    slot_load  [NUM_SLOTS];
  logic [CW-1:0] slot_cnt   [NUM_SLOTS];

  // Scan counters and search results.
  logic [SW-1:0] scan_s;
  logic [FW-1:0] scan_f;
  logic [AW-1:0] scan_addr;
  logic          have_match;
  logic [SW-1:0] match_idx;
  logic          have_free;
  logic [SW-1:0] free_idx;
  logic          chk_valid;
  logic          chk_elig;
  logic [SW-1:0] chk_slot;
  logic          best_valid;
  logic [SW-1:0] best_idx;
  logic [6:0]    best_load;

  // Finish-stage decisions.
  logic          out_free;
  logic          key_hit;
  logic [SW-1:0] tgt;
  logic [CW-1:0] tgt_cnt;
  logic          do_alloc;
  logic          do_append;
  status_t       fin_status;
  logic          key_wr_en;
  logic [AW-1:0] key_wr_addr;

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !resp_valid || !resp_stall;

  // Resolve the request once the scan is over.
  always_comb begin
    tgt        = match_idx;
    tgt_cnt    = slot_cnt[match_idx];
    do_alloc   = 1'b0;
    do_append  = 1'b0;
    fin_status = ST_NOT_FOUND;
    case (cur_action)
      ACT_REGISTER: begin
        if (have_match) begin
          tgt     = match_idx;
          tgt_cnt = slot_cnt[match_idx];
        end else if (have_free) begin
          tgt      = free_idx;
          tgt_cnt  = '0;
          do_alloc = 1'b1;
        end
        if (!have_match && !have_free) begin
          fin_status = ST_TABLE_FULL;
        end else if (tgt_cnt >= FULL_CNT) begin
          fin_status = ST_LIST_FULL;
        end else begin
          fin_status = ST_REGISTERED;
          do_append  = 1'b1;
        end
      end
      ACT_LOOKUP: begin
        fin_status = best_valid ? ST_FOUND : ST_NOT_FOUND;
      end
      ACT_DISCONNECT: begin
        fin_status = have_match ? ST_DISCONNECTED : ST_UNKNOWN;
      end
      default: begin
        fin_status = ST_NOT_FOUND;
      end
    endcase
  end

  assign key_wr_en   = (state == S_FINISH) && out_free && do_append;
  assign key_wr_addr = AW'(tgt) * ROW_SIZE + AW'(tgt_cnt);

  llfd_key_store #(
    .DEPTH (DEPTH)
  ) u_key_store (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (key_wr_addr),
    .wr_key  (cur_key),
    .rd_addr (scan_addr),
    .cmp_key (cur_key),
    .hit     (key_hit)
  );

  // Sequencer, slot table and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      load_limit <= LOAD_LIMIT_RESET;
      resp_valid <= 1'b0;
      chk_valid  <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_used[i] <= 1'b0;
        slot_load[i] <= '0;
        slot_cnt[i]  <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        load_limit <= cfg_data;
      end
      // A beat taken while a new response is loaded is refilled by the finish stage.
      if (resp_valid && !resp_stall && (state != S_FINISH)) begin
        resp_valid <= 1'b0;
      end

      // One key check per cycle, made in the cycle after its memory read.
      chk_valid <= (state == S_KEY_SCAN);
      chk_slot  <= scan_s;
      chk_elig  <= slot_used[scan_s] && (CW'(scan_f) < slot_cnt[scan_s]);
      if (chk_valid && chk_elig && key_hit && (slot_load[chk_slot] < best_load)) begin
        best_valid <= 1'b1;
        best_idx   <= chk_slot;
        best_load  <= slot_load[chk_slot];
      end

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur_action <= req.action;
            cur_port   <= req.client_port;
            cur_key    <= req.file_key;
            scan_s     <= '0;
            scan_f     <= '0;
            scan_addr  <= '0;
            have_match <= 1'b0;
            have_free  <= 1'b0;
            best_valid <= 1'b0;
            best_load  <= load_limit;
            case (req.action)
              ACT_REGISTER, ACT_DISCONNECT: state <= S_SLOT_SCAN;
              ACT_LOOKUP:                   state <= S_KEY_SCAN;
              default:                      state <= S_FINISH;
            endcase
          end
        end

        // Lowest slot holding the port and lowest free slot.
        S_SLOT_SCAN: begin
          if (slot_used[scan_s] && (slot_port[scan_s] == cur_port) && !have_match) begin
            have_match <= 1'b1;
            match_idx  <= scan_s;
          end
          if (!slot_used[scan_s] && !have_free) begin
            have_free <= 1'b1;
            free_idx  <= scan_s;
          end
          if (scan_s == LAST_SLOT) begin
            state <= S_FINISH;
          end else begin
            scan_s <= scan_s + 1'b1;
          end
        end

        // Issue one key memory read per cycle across every slot and file position.
        S_KEY_SCAN: begin
          if (scan_f == LAST_FILE) begin
            scan_f <= '0;
            if (scan_s == LAST_SLOT) begin
              state <= S_KEY_DRAIN;
            end else begin
              scan_s    <= scan_s + 1'b1;
              scan_addr <= scan_addr + 1'b1;
            end
          end else begin
            scan_f    <= scan_f + 1'b1;
            scan_addr <= scan_addr + 1'b1;
          end
        end

        // The last read is checked in this cycle.
        S_KEY_DRAIN: begin
          state <= S_FINISH;
        end

        // Commit the table update and hand the response to the output register.
        S_FINISH: begin
          if (out_free) begin
            resp_valid         <= 1'b1;
            resp.status        <= fin_status;
            resp.server_port   <= ((cur_action == ACT_LOOKUP) && best_valid) ?
                                  slot_port[best_idx] : '0;
            state              <= S_IDLE;
            case (cur_action)
              ACT_REGISTER: begin
                if (do_alloc) begin
                  slot_used[tgt] <= 1'b1;
                  slot_port[tgt] <= cur_port;
                  slot_load[tgt] <= '0;
                end
                if (do_append) begin
                  slot_cnt[tgt] <= tgt_cnt + 1'b1;
                end
              end
              ACT_LOOKUP: begin
                if (best_valid) begin
                  if (slot_load[best_idx] != LOAD_MAX) begin
                    slot_load[best_idx] <= slot_load[best_idx] + 1'b1;
                  end
                end
              end
              ACT_DISCONNECT: begin
                if (have_match) begin
                  slot_used[match_idx] <= 1'b0;
                  slot_load[match_idx] <= '0;
                  slot_cnt[match_idx]  <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### test/tb_least_loaded_file_directory.sv
module tb_least_loaded_file_directory;
  timeunit 1ns;
  timeprecision 1ps;

  import llfd_pkg::*;

  localparam int NSLOTS = NUM_SLOTS_DEF;
  localparam int NFILES = FILES_PER_SLOT_DEF;
  // The fourth action code has no meaning and must be answered as not found.
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int NPHASES = 7;
  localparam int LONG_HOLD = 400;

  logic       clk;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  req_t       req = '0;
  logic       resp_valid;
  logic       resp_stall = 1'b0;
  resp_t      resp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = '0;

  least_loaded_file_directory DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .resp_valid(resp_valid),
    .resp_stall(resp_stall),
    .resp      (resp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the client directory, updated as each request beat is accepted.
  bit          dir_used   [NSLOTS];
  logic [15:0] dir_port   [NSLOTS];
  bit   [6:0]  dir_load   [NSLOTS];
  int          dir_nfiles [NSLOTS];
  logic [63:0] dir_keys   [NSLOTS][NFILES];
  logic [6:0]  dir_limit = LOAD_LIMIT_RESET;

  // Replies the directory owes, oldest first.
  resp_t awaited_replies[$];

  // Pools that keep random traffic on a few clients and files so that lookups hit.
  logic [15:0] port_pool[16];
  logic [63:0] key_pool[8];

  int  errors = 0;
  int  n_sent = 0;
  int  n_replies = 0;
  int  status_seen[8];
  bit  long_hold_due = 1'b0;

  typedef struct {
    req_t        r;
    bit          typed;
    status_t     st;
    logic [15:0] sport;
  } plan_row_t;

  plan_row_t opening[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("[least_loaded_file_directory] ERROR");
    $finish;
  end

  // Lowest used slot holding this port, or NSLOTS when the client is unknown.
  function automatic int slot_of(input logic [15:0] port);
    for (int s = 0; s < NSLOTS; s++)
      if (dir_used[s] && dir_port[s] == port) return s;
    return NSLOTS;
  endfunction

  // Work out the reply to one request and apply its effect to the shadow directory.
  function automatic resp_t directory_answer(input req_t r);
    resp_t      a;
    int         s;
    int         best;
    logic [6:0] best_load;
    a.status = ST_NOT_FOUND;
    a.server_port = '0;
    case (r.action)
      ACT_REGISTER: begin
        s = slot_of(r.client_port);
        if (s == NSLOTS) begin
          s = 0;
          while (s < NSLOTS && dir_used[s]) s++;
          if (s < NSLOTS) begin
            dir_used[s] = 1'b1;
            dir_port[s] = r.client_port;
            dir_load[s] = '0;
            dir_nfiles[s] = 0;
          end
        end
        if (s == NSLOTS) begin
          a.status = ST_TABLE_FULL;
        end else if (dir_nfiles[s] >= NFILES) begin
          a.status = ST_LIST_FULL;
        end else begin
          dir_keys[s][dir_nfiles[s]] = r.file_key;
          dir_nfiles[s]++;
          a.status = ST_REGISTERED;
        end
      end
      ACT_LOOKUP: begin
        best = NSLOTS;
        best_load = dir_limit;
        for (int q = 0; q < NSLOTS; q++) begin
          if (dir_used[q]) begin
            for (int f = 0; f < dir_nfiles[q]; f++)
              if (dir_keys[q][f] == r.file_key && dir_load[q] < best_load) begin
                best_load = dir_load[q];
                best = q;
              end
          end
        end
        if (best < NSLOTS) begin
          if (dir_load[best] != LOAD_MAX) dir_load[best]++;
          a.status = ST_FOUND;
          a.server_port = dir_port[best];
        end
      end
      ACT_DISCONNECT: begin
        s = slot_of(r.client_port);
        if (s == NSLOTS) begin
          a.status = ST_UNKNOWN;
        end else begin
          dir_used[s] = 1'b0;
          dir_load[s] = '0;
          dir_nfiles[s] = 0;
          a.status = ST_DISCONNECTED;
        end
      end
      default: a.status = ST_NOT_FOUND;
    endcase
    return a;
  endfunction

  function automatic plan_row_t plan_row(input logic [1:0] act, input logic [15:0] port,
                                         input logic [63:0] key, input bit typed,
                                         input status_t st, input logic [15:0] sport);
    plan_row_t p;
    p.r.action = act;
    p.r.client_port = port;
    p.r.file_key = key;
    p.typed = typed;
    p.st = st;
    p.sport = sport;
    return p;
  endfunction

  // Mostly back to back, often a few cycles, now and then a long pause.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Well-formed traffic on the pooled clients and files, with some stray values mixed in.
  function automatic req_t random_request(input int n_ports, input int disc_pct);
    req_t r;
    int   pick;
    r.client_port = 16'($urandom);
    r.file_key = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      r.action = ACT_SPARE;
    end else if (pick < 4 + disc_pct) begin
      r.action = ACT_DISCONNECT;
      if ($urandom_range(0, 9) != 0) r.client_port = port_pool[$urandom_range(0, n_ports - 1)];
    end else if (pick < 4 + disc_pct + (96 - disc_pct) * 55 / 100) begin
      r.action = ACT_REGISTER;
      if ($urandom_range(0, 9) != 0) r.client_port = port_pool[$urandom_range(0, n_ports - 1)];
      if ($urandom_range(0, 6) != 0) r.file_key = key_pool[$urandom_range(0, 7)];
    end else begin
      r.action = ACT_LOOKUP;
      if ($urandom_range(0, 6) != 0) r.file_key = key_pool[$urandom_range(0, 7)];
    end
    return r;
  endfunction

  // Present one request beat and hold it until the directory takes it.
  task automatic offer(input req_t r, input bit typed, input resp_t want);
    resp_t predicted;
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    predicted = directory_answer(r);
    awaited_replies.push_back(typed ? want : predicted);
    n_sent++;
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending and let every owed reply come back before touching the limit.
  task automatic settle();
    req_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [6:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dir_limit = v;
  endtask

  // Disconnect every client still in the table so that a phase starts empty.
  task automatic flush_clients();
    logic [15:0] gone[$];
    req_t        r;
    for (int s = 0; s < NSLOTS; s++)
      if (dir_used[s]) gone.push_back(dir_port[s]);
    foreach (gone[i]) begin
      r.action = ACT_DISCONNECT;
      r.client_port = gone[i];
      r.file_key = {$urandom, $urandom};
      offer(r, 1'b0, '0);
      idle_gap(gap_len());
    end
  endtask

  // Reply side: random stall runs, plus one long hold-off when asked for.
  initial begin : reply_sink
    int run_left;
    bit run_stall;
    int roll;
    run_left = 0;
    run_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        run_stall = 1'b1;
        run_left = LONG_HOLD;
      end else if (run_left == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
          run_stall = 1'b0;
          run_left = $urandom_range(1, 30);
        end else if (roll < 92) begin
          run_stall = 1'b1;
          run_left = $urandom_range(1, 4);
        end else begin
          run_stall = 1'b1;
          run_left = $urandom_range(10, 40);
        end
      end
      resp_stall <= run_stall;
      run_left--;
    end
  end

  // Check every accepted reply beat against the oldest owed reply.
  always @(posedge clk) begin
    resp_t want;
    if (!rst && resp_valid && !resp_stall) begin
      n_replies++;
      if (awaited_replies.size() == 0) begin
        $display("%0t: reply with none owed, actual status %0d port %h",
                 $time, resp.status, resp.server_port);
        errors++;
      end else begin
        want = awaited_replies.pop_front();
        status_seen[want.status]++;
        if (resp.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, resp.status);
          errors++;
        end
        if (resp.server_port !== want.server_port) begin
          $display("%0t: server_port mismatch, expected %h, actual %h",
                   $time, want.server_port, resp.server_port);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int          phase_limit[NPHASES];
    int          phase_items[NPHASES];
    int          phase_ports[NPHASES];
    int          phase_disc[NPHASES];
    int          lim;
    resp_t       want;
    req_t        r;
    logic [63:0] hot_key;

    phase_limit = '{100, 1, 127, 0, -1, 3, -1};
    phase_items = '{110, 70, 70, 40, 110, 110, 70};
    phase_ports = '{12, 4, 16, 8, 10, 6, 12};
    phase_disc  = '{15, 3, 2, 10, 10, 8, 12};

    // Opening checks: empty table, extremes of port and key, duplicates, ties, errors.
    opening.push_back(plan_row(ACT_LOOKUP, 16'h0000, 64'h0, 1, ST_NOT_FOUND, 16'h0));
    opening.push_back(plan_row(ACT_DISCONNECT, 16'h0000, 64'h0, 1, ST_UNKNOWN, 16'h0));
    opening.push_back(plan_row(ACT_SPARE, 16'hFFFF, '1, 1, ST_NOT_FOUND, 16'h0));
    opening.push_back(plan_row(ACT_REGISTER, 16'hFFFF, '1, 1, ST_REGISTERED, 16'h0));
    opening.push_back(plan_row(ACT_LOOKUP, 16'h0000, '1, 1, ST_FOUND, 16'hFFFF));
    opening.push_back(plan_row(ACT_REGISTER, 16'h0000, 64'h0, 1, ST_REGISTERED, 16'h0));
    opening.push_back(plan_row(ACT_REGISTER, 16'h0000, 64'h0, 1, ST_REGISTERED, 16'h0));
    opening.push_back(plan_row(ACT_LOOKUP, 16'h0000, 64'h0, 1, ST_FOUND, 16'h0000));
    opening.push_back(plan_row(ACT_REGISTER, 16'hFFFF, 64'h0, 1, ST_REGISTERED, 16'h0));
    opening.push_back(plan_row(ACT_LOOKUP, 16'h1234, 64'h0, 0, ST_FOUND, 16'h0));
    opening.push_back(plan_row(ACT_LOOKUP, 16'h8000, 64'h0, 0, ST_FOUND, 16'h0));
    opening.push_back(plan_row(ACT_REGISTER, 16'h8000, 64'h8000_0000_0000_0001, 0,
                               ST_REGISTERED, 16'h0));
    opening.push_back(plan_row(ACT_LOOKUP, 16'h0000, 64'h8000_0000_0000_0001, 0,
                               ST_FOUND, 16'h0));
    opening.push_back(plan_row(ACT_DISCONNECT, 16'hFFFF, 64'h0, 1, ST_DISCONNECTED, 16'h0));
    opening.push_back(plan_row(ACT_DISCONNECT, 16'hFFFF, '1, 1, ST_UNKNOWN, 16'h0));
    opening.push_back(plan_row(ACT_LOOKUP, 16'hFFFF, '1, 1, ST_NOT_FOUND, 16'h0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    foreach (opening[i]) begin
      want.status = opening[i].st;
      want.server_port = opening[i].sport;
      offer(opening[i].r, opening[i].typed, want);
      idle_gap(gap_len());
    end

    // Random phases, each under its own load limit and traffic mix.
    for (int p = 0; p < NPHASES; p++) begin
      settle();
      lim = (phase_limit[p] < 0) ? $urandom_range(1, 127) : phase_limit[p];
      write_limit(lim[6:0]);
      flush_clients();
      foreach (port_pool[i]) port_pool[i] = 16'($urandom);
      port_pool[0] = 16'h0000;
      port_pool[1] = 16'hFFFF;
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = 64'h0;
      key_pool[1] = '1;
      for (int i = 0; i < phase_items[p]; i++) begin
        // Hold replies back for a long while so the request side backs up.
        if (p == 4 && i == 20) long_hold_due = 1'b1;
        offer(random_request(phase_ports[p], phase_disc[p]), 1'b0, '0);
        idle_gap(gap_len());
      end
    end

    // Drive one client's load up to the top of the range, which is also the limit, and keep looking it up.
    settle();
    write_limit(LOAD_MAX);
    flush_clients();
    hot_key = {$urandom, $urandom};
    r.action = ACT_REGISTER;
    r.client_port = 16'($urandom);
    r.file_key = hot_key;
    offer(r, 1'b0, '0);
    for (int i = 0; i < 130; i++) begin
      idle_gap(gap_len());
      r.action = ACT_LOOKUP;
      r.client_port = 16'($urandom);
      r.file_key = hot_key;
      offer(r, 1'b0, '0);
    end

    req_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);

    $display("Covered %0d requests and %0d replies under load limits 0, 1, 3, 100, 127%s",
             n_sent, n_replies, " and random.");
    $display("Replies: registered %0d, found %0d, not found %0d, disconnected %0d,",
             status_seen[ST_REGISTERED], status_seen[ST_FOUND], status_seen[ST_NOT_FOUND],
             status_seen[ST_DISCONNECTED]);
    $display("  unknown %0d, table full %0d, list full %0d",
             status_seen[ST_UNKNOWN], status_seen[ST_TABLE_FULL],
             status_seen[ST_LIST_FULL]);
    if (errors == 0) begin
      $display("[least_loaded_file_directory] OK");
    end else begin
      $display("[least_loaded_file_directory] ERROR");
    end
    $finish;
  end

endmodule
